// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clock, reset, cond, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define ASSERT_IMPLIES(label, clock, reset, pre, post, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clock, reset, cond, msg)
`define ASSERT_IMPLIES(label, clock, reset, pre, post, msg)
`endif
`endif

// ===== hdl/qcft_pkg.sv =====
// ---------------------------------------------------------------------------
// qcft_pkg
// shared constants and register codes of the quad code frame transform
// ---------------------------------------------------------------------------
`default_nettype none
package qcft_pkg;
  localparam int COORD_BITS_DEF     = 16;
  localparam int CODE_FRAC_BITS_DEF = 14;
  localparam int CODE_W             = 16;
  localparam int LIMIT_W            = 33;
  // quotient bits kept: code range plus overflow bit plus rounding bit
  localparam int QUO_BITS           = CODE_W + 2;

  typedef enum logic [1:0] {
    CFG_MIN_SQ_DIST = 2'd0,
    CFG_MAX_SQ_DIST = 2'd1,
    CFG_CIRCLE_MODE = 2'd2
  } cfg_idx_t;
endpackage
`default_nettype wire

// ===== hdl/quad_code_frame_transform.sv =====
// result path: stages 1 to 3, divider setup stage, the divider stages, output register
// throughput: one request per cycle while the output is not held; the restoring divider is unrolled, one
//   quotient bit per register stage, so every stage takes a new item each cycle unless the output is held
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// reset (rst, synchronous): pipeline empty, limits 0 and 2^33-1, square mode
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// quad_code_frame_transform
// maps candidate star C into the frame of star pair A,B and tests its place
// ---------------------------------------------------------------------------
module quad_code_frame_transform #(
  parameter int COORD_BITS     = qcft_pkg::COORD_BITS_DEF,
  parameter int CODE_FRAC_BITS = qcft_pkg::CODE_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [COORD_BITS-1:0]        a_x,
  input  wire logic signed [COORD_BITS-1:0]        a_y,
  input  wire logic signed [COORD_BITS-1:0]        b_x,
  input  wire logic signed [COORD_BITS-1:0]        b_y,
  input  wire logic signed [COORD_BITS-1:0]        c_x,
  input  wire logic signed [COORD_BITS-1:0]        c_y,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     pair_ok,
  output logic                                     inside_res,
  output logic signed [qcft_pkg::CODE_W-1:0]       code_x,
  output logic signed [qcft_pkg::CODE_W-1:0]       code_y,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire qcft_pkg::cfg_idx_t                  cfg_index,
  input  wire logic [qcft_pkg::LIMIT_W-1:0]        cfg_data
);
  import qcft_pkg::*;

  // widths: differences, rotated axis, products, numerators, squared distance
  localparam int CW  = COORD_BITS + 1;
  localparam int UW  = COORD_BITS + 2;
  localparam int PW  = CW + UW;
  localparam int NW  = 2 * COORD_BITS + 4;
  localparam int SW  = 2 * COORD_BITS + 1;
  localparam int LW  = (SW > LIMIT_W) ? SW : LIMIT_W;
  localparam int RW  = NW + CODE_FRAC_BITS + 1;
  localparam int XW  = ((RW > SW + QUO_BITS) ? RW : SW + QUO_BITS) + 1;
  localparam int QB  = QUO_BITS;
  localparam logic [QB:0] CODE_POS_MAX = (QB+1)'((1 << (CODE_W - 1)) - 1);
  localparam logic [QB:0] CODE_NEG_MAG = (QB+1)'(1 << (CODE_W - 1));

  // configuration registers, to be written only while idle; the block itself does not enforce this
  logic [LIMIT_W-1:0] min_sq_dist;
  logic [LIMIT_W-1:0] max_sq_dist;
  logic               circle_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sq_dist <= '0;
      max_sq_dist <= '1;
      circle_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_SQ_DIST: min_sq_dist <= cfg_data;
        CFG_MAX_SQ_DIST: max_sq_dist <= cfg_data;
        CFG_CIRCLE_MODE: circle_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // one enable for every stage: the pipeline moves unless the output is held
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---- stage 1: differences to A and the rotated axes u = dx+dy, v = dy-dx
  logic signed [CW-1:0] dx_n, dy_n, cx_n, cy_n;
  logic signed [UW-1:0] u_n, v_n;
  always_comb begin
    dx_n = CW'(b_x) - CW'(a_x);
    dy_n = CW'(b_y) - CW'(a_y);
    cx_n = CW'(c_x) - CW'(a_x);
    cy_n = CW'(c_y) - CW'(a_y);
    u_n  = UW'(dx_n) + UW'(dy_n);
    v_n  = UW'(dy_n) - UW'(dx_n);
  end

  logic                 v1;
  logic signed [CW-1:0] dx1, dy1, cx1, cy1;
  logic signed [UW-1:0] u1, vv1;

  // ---- stage 2: all products
  logic                     v2;
  logic signed [2*CW-1:0]   pdd2, pee2, pcc2, pyy2, pxd2, pyd2;
  logic signed [PW-1:0]     pxu2, pyv2, pyu2, pxv2;

  // ---- stage 3: squared distance and the exact numerators
  logic                 v3;
  logic [SW-1:0]        s3;
  logic signed [NW-1:0] nx3, ny3, lhs3, rhs3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1  <= dx_n;
      dy1  <= dy_n;
      cx1  <= cx_n;
      cy1  <= cy_n;
      u1   <= u_n;
      vv1  <= v_n;
      pdd2 <= dx1 * dx1;
      pee2 <= dy1 * dy1;
      pcc2 <= cx1 * cx1;
      pyy2 <= cy1 * cy1;
      pxd2 <= cx1 * dx1;
      pyd2 <= cy1 * dy1;
      pxu2 <= PW'(cx1) * PW'(u1);
      pyv2 <= PW'(cy1) * PW'(vv1);
      pyu2 <= PW'(cy1) * PW'(u1);
      pxv2 <= PW'(cx1) * PW'(vv1);
      s3   <= SW'(pdd2) + SW'(pee2);
      nx3  <= NW'(pxu2) + NW'(pyv2);
      ny3  <= NW'(pyu2) - NW'(pxv2);
      lhs3 <= NW'(pcc2) + NW'(pyy2);
      rhs3 <= NW'(pxd2) + NW'(pyd2);
    end
  end

  // ---- stage 4: limit check, inside test, divider setup
  logic                 ok_n, in_n, ovx_n, ovy_n;
  logic signed [NW-1:0] s3_sig;
  logic [NW-1:0]        magx_n, magy_n;
  logic [XW-1:0]        remx_n, remy_n, slim_n;
  always_comb begin
    s3_sig = $signed(NW'(s3));
    ok_n   = (s3 != '0) && (LW'(s3) >= LW'(min_sq_dist)) && (LW'(s3) <= LW'(max_sq_dist));
    if (circle_mode) begin
      in_n = (lhs3 <= rhs3);
    end else begin
      in_n = !nx3[NW-1] && (nx3 <= s3_sig) && !ny3[NW-1] && (ny3 <= s3_sig);
    end
    magx_n = nx3[NW-1] ? NW'(-nx3) : NW'(nx3);
    magy_n = ny3[NW-1] ? NW'(-ny3) : NW'(ny3);
    // dividend carries one extra fraction bit for round half away from zero
    remx_n = XW'(magx_n) << (CODE_FRAC_BITS + 1);
    remy_n = XW'(magy_n) << (CODE_FRAC_BITS + 1);
    slim_n = XW'(s3) << QB;
    ovx_n  = remx_n >= slim_n;
    ovy_n  = remy_n >= slim_n;
  end

  // divider pipeline: index 0 is the setup stage, index QB holds the quotient
  logic          dvv   [0:QB];
  logic          dok   [0:QB];
  logic          din   [0:QB];
  logic          dnx   [0:QB];
  logic          dny   [0:QB];
  logic          dovx  [0:QB];
  logic          dovy  [0:QB];
  logic [SW-1:0] ds    [0:QB];
  logic [XW-1:0] dremx [0:QB];
  logic [XW-1:0] dremy [0:QB];
  logic [QB-1:0] dqx   [0:QB];
  logic [QB-1:0] dqy   [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dok[0]   <= ok_n;
      din[0]   <= in_n;
      dnx[0]   <= nx3[NW-1];
      dny[0]   <= ny3[NW-1];
      dovx[0]  <= ovx_n;
      dovy[0]  <= ovy_n;
      ds[0]    <= s3;
      dremx[0] <= remx_n;
      dremy[0] <= remy_n;
      dqx[0]   <= '0;
      dqy[0]   <= '0;
    end
  end

  // one restoring step per stage, quotient bit QB-1-k at stage k
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    logic [XW-1:0] dsor;
    logic          bx, by;
    logic [QB-1:0] qx_n, qy_n;
    always_comb begin
      dsor = XW'(ds[k]) << SH;
      bx   = dremx[k] >= dsor;
      by   = dremy[k] >= dsor;
      qx_n = dqx[k];
      qy_n = dqy[k];
      qx_n[SH] = bx;
      qy_n[SH] = by;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (adv) begin
        dvv[k+1] <= dvv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dok[k+1]   <= dok[k];
        din[k+1]   <= din[k];
        dnx[k+1]   <= dnx[k];
        dny[k+1]   <= dny[k];
        dovx[k+1]  <= dovx[k];
        dovy[k+1]  <= dovy[k];
        ds[k+1]    <= ds[k];
        dremx[k+1] <= bx ? dremx[k] - dsor : dremx[k];
        dremy[k+1] <= by ? dremy[k] - dsor : dremy[k];
        dqx[k+1]   <= qx_n;
        dqy[k+1]   <= qy_n;
      end
    end
  end

  // ---- output stage: round, saturate, clear on a rejected pair
  logic [QB:0]          qrx, qry;
  logic [CODE_W-1:0]    cx_n2, cy_n2;
  always_comb begin
    qrx = ({1'b0, dqx[QB]} + (QB+1)'(1)) >> 1;
    qry = ({1'b0, dqy[QB]} + (QB+1)'(1)) >> 1;
    if (dnx[QB]) begin
      cx_n2 = (dovx[QB] || qrx >= CODE_NEG_MAG) ? CODE_W'(CODE_NEG_MAG) : CODE_W'(-qrx);
    end else begin
      cx_n2 = (dovx[QB] || qrx > CODE_POS_MAX) ? CODE_W'(CODE_POS_MAX) : CODE_W'(qrx);
    end
    if (dny[QB]) begin
      cy_n2 = (dovy[QB] || qry >= CODE_NEG_MAG) ? CODE_W'(CODE_NEG_MAG) : CODE_W'(-qry);
    end else begin
      cy_n2 = (dovy[QB] || qry > CODE_POS_MAX) ? CODE_W'(CODE_POS_MAX) : CODE_W'(qry);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dvv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pair_ok    <= dok[QB];
      inside_res <= dok[QB] && din[QB];
      code_x     <= dok[QB] ? $signed(cx_n2) : '0;
      code_y     <= dok[QB] ? $signed(cy_n2) : '0;
    end
  end

  // a rejected pair carries no test result and no codes
  `ASSERT_IMPLIES(a_reject_clear, clk, rst, out_valid && !pair_ok, !inside_res && code_x == '0 && code_y == '0, "rejected pair with nonzero result")
  // an accepted pair never has a zero distance
  `ASSERT_IMPLIES(a_ok_nonzero, clk, rst, dvv[QB] && dok[QB], ds[QB] != '0, "zero distance accepted")
  // a held result keeps the whole pipeline frozen
  `ASSERT_IMPLIES(a_hold_freeze, clk, rst, out_valid && !out_ready, in_ready == 1'b0, "pipeline moved under stall")

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the quad code frame transform: a queue-fed driver
// sends star triples, a scoreboard predicts scale check, inside test and codes
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import qcft_pkg::*;

  localparam longint unsigned SQ_ALL = 64'h1_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [15:0] ax, ay, bx, by, cx, cy;
  } quad_req_t;

  typedef struct packed {
    logic               ok;
    logic               hit;
    logic signed [15:0] kx, ky;
  } quad_code_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0, c_x = '0, c_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic pair_ok, inside_res;
  logic signed [15:0] code_x, code_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_MIN_SQ_DIST;
  logic [LIMIT_W-1:0] cfg_data = '0;

  // local copy of the limit registers
  longint unsigned lim_min = 0;
  longint unsigned lim_max = SQ_ALL;
  logic            circ_mode = 1'b0;

  quad_req_t  pending_quads[$];
  quad_code_t expected_codes[$];
  int err_cnt = 0;
  logic quiet = 1'b0;     // no idling on either side
  logic hold_req = 1'b0;  // ask the receiver for one long hold-off

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  quad_code_frame_transform uut (
    .clk, .rst, .in_valid, .in_ready, .a_x, .a_y, .b_x, .b_y, .c_x, .c_y,
    .out_valid, .out_ready, .pair_ok, .inside_res, .code_x, .code_y,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // round num*2^14/s to nearest, ties away from zero, saturated to 16 bits
  function automatic logic [15:0] code_round(longint num, longint unsigned s);
    logic neg;
    longint unsigned mag, q, r;
    logic sat;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    q = mag / s;
    r = mag % s;
    sat = q > 64'd32768;
    for (int i = 0; i < 14; i++) begin
      if (!sat) begin
        q = q << 1;
        r = r << 1;
        if (r >= s) begin
          r = r - s;
          q = q + 1;
        end
        if (q > 64'd65536) sat = 1'b1;
      end
    end
    if (!sat && 2 * r >= s) q = q + 1;
    if (neg) begin
      if (sat || q >= 64'd32768) return 16'h8000;
      return 16'((~q) + 1);
    end
    if (sat || q > 64'd32767) return 16'h7fff;
    return q[15:0];
  endfunction

  function automatic quad_code_t predict_code(quad_req_t t);
    quad_code_t res;
    longint dx, dy, cx, cy, u, v, nx, ny;
    longint unsigned s;
    dx = longint'(t.bx) - longint'(t.ax);
    dy = longint'(t.by) - longint'(t.ay);
    cx = longint'(t.cx) - longint'(t.ax);
    cy = longint'(t.cy) - longint'(t.ay);
    s = dx * dx + dy * dy;
    res = '0;
    if (s == 0 || s < lim_min || s > lim_max) return res;
    u = dx + dy;
    v = dy - dx;
    nx = cx * u + cy * v;
    ny = cy * u - cx * v;
    res.ok = 1'b1;
    if (circ_mode) res.hit = (cx * cx + cy * cy) <= (cx * dx + cy * dy);
    else res.hit = nx >= 0 && nx <= longint'(s) && ny >= 0 && ny <= longint'(s);
    res.kx = code_round(nx, s);
    res.ky = code_round(ny, s);
    return res;
  endfunction

  // driver: keeps a request steady until accepted, then maybe idles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_codes.push_back(predict_code({a_x, a_y, b_x, b_y, c_x, c_y}));
      if (!in_valid || in_ready) begin
        if (pending_quads.size() > 0 && (quiet || $urandom_range(99) >= 22)) begin
          {a_x, a_y, b_x, b_y, c_x, c_y} <= pending_quads.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, one long hold-off, compare with oldest expectation
  int   hold_cnt = 0;
  logic hold_started = 1'b0;
  always @(posedge clk) begin
    quad_code_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: unexpected result ok=%b in=%b x=%0d y=%0d", $time,
                   pair_ok, inside_res, code_x, code_y);
          err_cnt++;
        end else begin
          want = expected_codes.pop_front();
          if (pair_ok !== want.ok) begin
            $display("%0t: pair_ok expected %b actual %b", $time, want.ok, pair_ok);
            err_cnt++;
          end
          if (inside_res !== want.hit) begin
            $display("%0t: inside_res expected %b actual %b", $time, want.hit,
                     inside_res);
            err_cnt++;
          end
          if (code_x !== want.kx) begin
            $display("%0t: code_x expected %0d actual %0d", $time, want.kx, code_x);
            err_cnt++;
          end
          if (code_y !== want.ky) begin
            $display("%0t: code_y expected %0d actual %0d", $time, want.ky, code_y);
            err_cnt++;
          end
        end
      end
      if (hold_req && !hold_started) begin
        hold_started <= 1'b1;
        hold_cnt <= 300;
        out_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || $urandom_range(99) >= 22;
      end
    end
  end

  // register write over the config channel, mirrored into the local copy
  task automatic write_reg(cfg_idx_t idx, longint unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[LIMIT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MIN_SQ_DIST: lim_min = val & SQ_ALL;
      CFG_MAX_SQ_DIST: lim_max = val & SQ_ALL;
      CFG_CIRCLE_MODE: circ_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic set_limits(longint unsigned lo, longint unsigned hi, logic circ);
    write_reg(CFG_MIN_SQ_DIST, lo);
    write_reg(CFG_MAX_SQ_DIST, hi);
    write_reg(CFG_CIRCLE_MODE, circ);
  endtask

  // wait until every queued quad is sent and every expected result is checked, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_quads.size() > 0 || in_valid || expected_codes.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_quad(int ax, int ay, int bx, int by, int cx, int cy);
    quad_req_t t;
    t.ax = 16'(ax); t.ay = 16'(ay); t.bx = 16'(bx);
    t.by = 16'(by); t.cx = 16'(cx); t.cy = 16'(cy);
    pending_quads.push_back(t);
  endtask

  // mostly plausible star triples near the AB frame, some raw noise
  task automatic add_random(int n);
    int ax, ay, dx, dy, k, sel, sp;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        add_quad($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (sel < 30) begin
        ax = $urandom; ay = $urandom;
        add_quad(ax, ay, ax, ay, $urandom, $urandom);
      end else begin
        sp = (sel < 80) ? 600 : 16000;
        ax = $urandom_range(32767) - 16384;
        ay = $urandom_range(32767) - 16384;
        dx = $urandom_range(2 * sp) - sp;
        dy = $urandom_range(2 * sp) - sp;
        k  = $urandom_range(2 * sp) - sp;
        add_quad(ax, ay, ax + dx, ay + dy,
                 ax + (dx + dy) / 2 + $urandom_range(2 * sp) - sp,
                 ay + (dy - dx) / 2 + k);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase: defaults, square test, directed corners
    set_limits(0, SQ_ALL, 1'b0);
    add_quad(0, 0, 16, 16, 0, 0);                // candidate on A
    add_quad(0, 0, 16, 16, 16, 16);              // candidate on B
    add_quad(0, 0, 16, 16, 0, 16);               // square corner
    add_quad(0, 0, 16, 16, 16, 0);
    add_quad(0, 0, 16, 16, 8, 8);
    add_quad(0, 0, 16, 16, 17, 16);              // just outside
    add_quad(0, 0, 16, 16, -1, 0);
    add_quad(5, 5, 5, 5, 7, 9);                  // zero distance
    add_quad(-32768, -32768, 32767, 32767, 0, 0);// largest distance
    add_quad(32767, 32767, -32768, -32768, 32767, -32768);
    add_quad(-32768, 32767, 32767, -32768, -32768, -32768);
    add_quad(0, 0, 1, 0, 32767, 32767);          // saturating codes
    add_quad(0, 0, 1, 0, -32768, -32768);
    add_quad(0, 0, 0, 1, -32768, 32767);
    add_quad(0, 0, 3, 0, 1, 0);                  // rounded fractional codes
    add_quad(0, 0, 3, 1, 2, 1);
    add_quad(-32768, -32768, -32768, -32768, -32768, -32768);
    add_quad(32767, 32767, 32767, 32767, 32767, 32767);
    add_random(280);
    wait_idle();

    // phase: circle test, long receiver hold-off fills the pipeline
    set_limits(0, SQ_ALL, 1'b1);
    add_quad(0, 0, 16, 16, 0, 16);
    add_quad(0, 0, 16, 16, -3, 19);
    hold_req <= 1'b1;
    add_random(300);
    wait_idle();

    // phase: narrow window, no idling
    quiet <= 1'b1;
    set_limits(64'd100000, 64'd4000000, 1'b0);
    add_random(300);
    wait_idle();
    quiet <= 1'b0;

    // phase: crossed limits reject everything
    set_limits(64'd5000000, 64'd1000, 1'b1);
    add_random(150);
    wait_idle();

    // phase: max of zero, then an out-of-range index that must be ignored
    set_limits(0, 0, 1'b0);
    write_reg(cfg_idx_t'(2'd3), SQ_ALL);
    add_random(150);
    wait_idle();

    // phase: only the largest distances pass, circle test
    set_limits(SQ_ALL - 64'd1000000000, SQ_ALL, 1'b1);
    add_random(200);
    wait_idle();

    // phase: full range again in square mode
    set_limits(1, SQ_ALL, 1'b0);
    add_random(480);
    wait_idle();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 200000);
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
